// File: src/rtsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_pkg
// Shared types and constants of the signed-count run-length text decoder.
// ----------------------------------------------------------------------------
package rtsc_pkg;

  localparam int COUNT_W = 7;
  localparam int MAG_W   = 10;

  localparam logic [7:0] CH_END   = 8'd0;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [1:0] {
    MODE_AWAIT = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_COPY  = 2'd2
  } parse_mode_t;

  typedef struct packed {
    logic accept;
    logic rep_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic starts_repeat;
    logic rep_last;
    logic out_valid;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/rtsc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_if
// Valid/ready channels: encoded text bytes in, decoded bytes out.
// ----------------------------------------------------------------------------
interface rtsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rtsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       count_saturated;

  modport source (output valid, output out_byte, output run_last,
                  output count_saturated, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input count_saturated, output ready);
endinterface
`default_nettype wire

// File: src/rle_text_signed_count_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rle_text_signed_count_decoder
// Run-length text decoder with signed counts and literal copy runs.
//
// in_ch carries one encoded text byte per transfer; out_ch carries decoded
// bytes with run_last and count_saturated. Count digits, '-', dropped bytes
// and the NUL terminator produce no output. A literal byte leaves the output
// register in the cycle after its input transfer. Throughput: one input byte
// per cycle while the output register drains and no repeat run plays out.
// A positive count N ends in a data byte after which the input is held off
// while the repeat counter plays the run out, one byte a cycle unless out_ch
// stalls, in which case the output register holds its byte and in_ch.ready
// drops; no byte is lost. rst (synchronous) clears the parser, the repeat
// counter and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rle_text_signed_count_decoder #(
  parameter int MAX_COUNT = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rtsc_in_if.sink    in_ch,
  rtsc_out_if.source out_ch
);

  rtsc_pkg::ctrl_cmd_t  cmd;
  rtsc_pkg::dp_status_t st;

  rtsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .in_ready  (in_ch.ready),
    .cmd       (cmd)
  );

  rtsc_datapath #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_byte         (in_ch.in_byte),
    .out_ready       (out_ch.ready),
    .cmd             (cmd),
    .st              (st),
    .out_byte        (out_ch.out_byte),
    .run_last        (out_ch.run_last),
    .count_saturated (out_ch.count_saturated)
  );

  assign out_ch.valid = st.out_valid;

`ifndef SYNTHESIS
  a_rep_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && st.starts_repeat |=> !in_ch.ready)
    else $error("input taken while a repeat run is pending");

  a_no_double_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.rep_load))
    else $error("input transfer during repeat playout");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

// File: src/rtsc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_ctrl
// Controller: takes bytes or plays out repeats, one a cycle unless stalled.
// ----------------------------------------------------------------------------
module rtsc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                out_ready,
  input  wire rtsc_pkg::dp_status_t st,
  output logic                     in_ready,
  output rtsc_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic {
    S_TAKE,
    S_REPEAT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !st.out_valid || out_ready;

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.rep_load = 1'b0;
    state_next   = state;
    unique case (state)
      S_TAKE: begin
        in_ready   = slot_free;
        cmd.accept = in_valid && slot_free;
        if (cmd.accept && st.starts_repeat) begin
          state_next = S_REPEAT;
        end
      end
      S_REPEAT: begin
        cmd.rep_load = slot_free;
        if (slot_free && st.rep_last) begin
          state_next = S_TAKE;
        end
      end
      default: begin
        state_next = S_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: src/rtsc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_datapath
// Token parser state, repeat run registers and the output register.
// ----------------------------------------------------------------------------
module rtsc_datapath #(
  parameter int MAX_COUNT = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          in_byte,
  input  wire logic                out_ready,
  input  wire rtsc_pkg::ctrl_cmd_t cmd,
  output rtsc_pkg::dp_status_t     st,
  output logic [7:0]               out_byte,
  output logic                     run_last,
  output logic                     count_saturated
);

  localparam int CW = rtsc_pkg::COUNT_W;
  localparam int MW = rtsc_pkg::MAG_W;
  localparam logic [MW-1:0] MAX_MAG = MW'(MAX_COUNT);

  rtsc_pkg::parse_mode_t parse_mode, parse_mode_next;
  logic [CW-1:0] run_count, run_count_next;
  logic          count_negative, count_negative_next;
  logic          sat_seen, sat_seen_next;

  logic [CW-1:0] rep_left;
  logic [7:0]    rep_byte;
  logic          rep_sat;
  logic          out_valid;

  logic [CW-1:0] rc_eff;
  logic          neg_eff;
  logic          sat_eff;
  logic [MW-1:0] mag;
  logic          is_digit;
  logic          emit_one;
  logic          emit_sat;
  logic          start_rep;

  assign is_digit = (in_byte >= rtsc_pkg::CH_ZERO) && (in_byte <= rtsc_pkg::CH_NINE);

  assign mag = {rc_eff, 3'b000} + {2'b00, rc_eff, 1'b0} + {6'd0, in_byte[3:0]};

  always_comb begin
    parse_mode_next     = parse_mode;
    run_count_next      = run_count;
    count_negative_next = count_negative;
    sat_seen_next       = sat_seen;
    emit_one            = 1'b0;
    emit_sat            = sat_seen;
    start_rep           = 1'b0;
    if (parse_mode == rtsc_pkg::MODE_COUNT) begin
      rc_eff  = run_count;
      neg_eff = count_negative;
      sat_eff = sat_seen;
    end else begin
      rc_eff  = '0;
      neg_eff = 1'b0;
      sat_eff = 1'b0;
    end
    if (in_byte == rtsc_pkg::CH_END) begin
      parse_mode_next     = rtsc_pkg::MODE_AWAIT;
      run_count_next      = '0;
      count_negative_next = 1'b0;
      sat_seen_next       = 1'b0;
    end else if (parse_mode == rtsc_pkg::MODE_COPY) begin
      emit_one = 1'b1;
      if (run_count <= CW'(1)) begin
        parse_mode_next     = rtsc_pkg::MODE_AWAIT;
        run_count_next      = '0;
        count_negative_next = 1'b0;
        sat_seen_next       = 1'b0;
      end else begin
        run_count_next = run_count - CW'(1);
      end
    end else if (parse_mode != rtsc_pkg::MODE_COUNT && in_byte == rtsc_pkg::CH_MINUS) begin
      parse_mode_next     = rtsc_pkg::MODE_COUNT;
      count_negative_next = 1'b1;
      run_count_next      = '0;
      sat_seen_next       = 1'b0;
    end else if (is_digit) begin
      parse_mode_next     = rtsc_pkg::MODE_COUNT;
      count_negative_next = neg_eff;
      if (mag > MAX_MAG) begin
        run_count_next = CW'(MAX_COUNT);
        sat_seen_next  = 1'b1;
      end else begin
        run_count_next = mag[CW-1:0];
        sat_seen_next  = sat_eff;
      end
    end else begin
      parse_mode_next     = rtsc_pkg::MODE_AWAIT;
      run_count_next      = '0;
      count_negative_next = 1'b0;
      sat_seen_next       = 1'b0;
      emit_sat            = sat_eff;
      if (rc_eff != '0) begin
        if (neg_eff) begin
          emit_one = 1'b1;
          if (rc_eff > CW'(1)) begin
            parse_mode_next     = rtsc_pkg::MODE_COPY;
            run_count_next      = rc_eff - CW'(1);
            count_negative_next = 1'b1;
            sat_seen_next       = sat_eff;
          end
        end else begin
          start_rep = 1'b1;
        end
      end
    end
  end

  assign st.starts_repeat = start_rep;
  assign st.rep_last      = (rep_left == CW'(1));
  assign st.out_valid     = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode     <= rtsc_pkg::MODE_AWAIT;
      run_count      <= '0;
      count_negative <= 1'b0;
      sat_seen       <= 1'b0;
      out_valid      <= 1'b0;
      rep_left       <= '0;
    end else begin
      if (cmd.accept) begin
        parse_mode     <= parse_mode_next;
        run_count      <= run_count_next;
        count_negative <= count_negative_next;
        sat_seen       <= sat_seen_next;
      end
      if (cmd.accept && start_rep) begin
        rep_left <= rc_eff;
      end else if (cmd.rep_load) begin
        rep_left <= rep_left - CW'(1);
      end
      if ((cmd.accept && emit_one) || cmd.rep_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && start_rep) begin
      rep_byte <= in_byte;
      rep_sat  <= sat_eff;
    end
    if (cmd.rep_load) begin
      out_byte        <= rep_byte;
      run_last        <= st.rep_last;
      count_saturated <= rep_sat;
    end else if (cmd.accept && emit_one) begin
      out_byte        <= in_byte;
      run_last        <= 1'b1;
      count_saturated <= emit_sat;
    end
  end

endmodule
`default_nettype wire

// File: test/rtsc_checker.sv
// ----------------------------------------------------------------------------
// rtsc_checker
// Watches both channels of the signed-count run-length decoder. It keeps its
// own copy of the token parser, queues the decoded bytes that each input
// transfer should produce, and compares every output transfer field by field
// against the oldest queued byte.
// ----------------------------------------------------------------------------
module rtsc_checker #(
  parameter int MAX_COUNT = 64
) (
  input  logic clk,
  input  logic rst,
  rtsc_in_if   in_ch,
  rtsc_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   checked_count,
  output int   sat_count
);
  import rtsc_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       count_saturated;
  } decoded_t;

  decoded_t decoded_q[$];

  parse_mode_t        tok_mode;
  logic [COUNT_W-1:0] tok_count;
  logic               tok_neg;
  logic               tok_sat;

  function automatic void clear_token();
    tok_mode  = MODE_AWAIT;
    tok_count = '0;
    tok_neg   = 1'b0;
    tok_sat   = 1'b0;
  endfunction

  function automatic void push_decoded(logic [7:0] b, logic last);
    decoded_q.push_back('{b, last, tok_sat});
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int mag;
    int reps;
    if (b == CH_END) begin
      clear_token();
      return;
    end
    if (tok_mode == MODE_COPY) begin
      push_decoded(b, 1'b1);
      if (tok_count <= 1) clear_token();
      else tok_count = tok_count - COUNT_W'(1);
      return;
    end
    if (tok_mode != MODE_COUNT && b == CH_MINUS) begin
      tok_mode  = MODE_COUNT;
      tok_neg   = 1'b1;
      tok_count = '0;
      tok_sat   = 1'b0;
      return;
    end
    if (tok_mode != MODE_COUNT) begin
      tok_count = '0;
      tok_neg   = 1'b0;
      tok_sat   = 1'b0;
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      mag = int'(tok_count) * 10 + int'(b) - int'(CH_ZERO);
      if (mag > MAX_COUNT) begin
        mag     = MAX_COUNT;
        tok_sat = 1'b1;
      end
      tok_count = mag[COUNT_W-1:0];
      tok_mode  = MODE_COUNT;
      return;
    end
    // data byte of the token
    if (tok_count == 0) begin
      clear_token();
      return;
    end
    if (tok_neg) begin
      push_decoded(b, 1'b1);
      if (tok_count <= 1) begin
        clear_token();
      end else begin
        tok_count = tok_count - COUNT_W'(1);
        tok_mode  = MODE_COPY;
      end
      return;
    end
    reps = (tok_count > MAX_COUNT) ? MAX_COUNT : int'(tok_count);
    for (int i = 0; i < reps; i++) push_decoded(b, i == reps - 1);
    clear_token();
  endfunction

  always @(posedge clk) begin : monitor
    decoded_t exp_r;
    if (rst) begin
      clear_token();
      decoded_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transfer: expected none, actual byte %02h last %0b sat %0b",
                   $time, out_ch.out_byte, out_ch.run_last, out_ch.count_saturated);
        end else begin
          exp_r = decoded_q.pop_front();
          checked_count++;
          if (exp_r.count_saturated) sat_count++;
          if (out_ch.out_byte !== exp_r.out_byte) begin
            fail_count++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, exp_r.out_byte, out_ch.out_byte);
          end
          if (out_ch.run_last !== exp_r.run_last) begin
            fail_count++;
            $display("%0t: run_last mismatch: expected %0b, actual %0b",
                     $time, exp_r.run_last, out_ch.run_last);
          end
          if (out_ch.count_saturated !== exp_r.count_saturated) begin
            fail_count++;
            $display("%0t: count_saturated mismatch: expected %0b, actual %0b",
                     $time, exp_r.count_saturated, out_ch.count_saturated);
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the decoder testbench. Drives encoded text into the block: a short
// directed set of tokens, a long output hold-off that backs up the input,
// then random tokens (repeat runs, literal runs, dropped bytes, terminators
// and noise) with random idling on both channels. The checker does the
// prediction and comparison; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import rtsc_pkg::*;

  localparam int MAX_COUNT   = 64;
  localparam int ITEM_TARGET = 220;

  logic clk;
  logic rst;

  rtsc_in_if  in_ch ();
  rtsc_out_if out_ch ();

  int fail_count;
  int pending;
  int checked_count;
  int sat_count;
  int sent_count;
  int long_holds;
  int stall_left;
  bit idle_on;
  bit long_hold_req;

  rle_text_signed_count_decoder #(.MAX_COUNT(MAX_COUNT)) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rtsc_checker #(.MAX_COUNT(MAX_COUNT)) chk (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_count(checked_count),
    .sat_count    (sat_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic int pick_count(bit literal);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, literal ? 6 : 8);
    if (r < (literal ? 95 : 90)) return $urandom_range(9, literal ? 20 : 64);
    return $urandom_range(65, 999);
  endfunction

  function automatic logic [7:0] pick_data();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b >= CH_ZERO && b <= CH_NINE);
    return b;
  endfunction

  task automatic send_count(input bit neg, input int n);
    string s;
    s = $sformatf("%0d", n);
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    if (neg) send_byte(CH_MINUS);
    send_str(s);
  endtask

  task automatic send_token();
    int kind;
    int n;
    bit neg;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      send_count(1'b0, pick_count(1'b0));
      send_byte(pick_data());
    end else if (kind < 80) begin
      n = pick_count(1'b1);
      send_count(1'b1, n);
      if (n > MAX_COUNT) n = MAX_COUNT;
      repeat (n) send_byte(8'($urandom_range(1, 255)));
    end else if (kind < 85) begin
      if ($urandom_range(0, 1)) send_byte(CH_ZERO);
      send_byte(pick_data());
    end else if (kind < 88) begin
      send_byte(CH_END);
    end else if (kind < 94) begin
      // token cut short by the terminator
      neg = 1'($urandom_range(0, 1));
      send_count(neg, pick_count(neg));
      if (neg) repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(1, 255)));
      send_byte(CH_END);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_req) begin
        stall_left    = 150;
        long_hold_req = 1'b0;
        long_holds++;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    idle_on = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_str("3a");
    send_str("-2xy");
    send_str("0z");
    send_str("--");
    send_str("q");
    send_str("99b");
    send_str("-9");
    send_byte(CH_END);
    send_byte(CH_ZERO + 8'd1);
    send_byte(8'hFF);
    send_str("-3A");
    send_byte(CH_END);
    send_byte(CH_ZERO + 8'd1);
    send_byte(8'h01);
    send_str("-1-");

    // hold the output off while the input keeps offering
    long_hold_req = 1'b1;
    send_str("-6xyz123");
    send_str("40Z");
    send_str("7q");

    while (sent_count < ITEM_TARGET) begin
      if (sent_count > ITEM_TARGET - 40) idle_on = 1'b0;
      send_token();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input transfers and %0d checked output bytes,",
             sent_count, checked_count);
    $display("%0d from clipped counts; output held off for %0d long stretch(es).",
             sat_count, long_holds);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rtsc_pkg.sv
src/rtsc_if.sv
src/rtsc_ctrl.sv
src/rtsc_datapath.sv
src/rle_text_signed_count_decoder.sv
test/rtsc_checker.sv
test/tb.sv
